>>> hdl/grid_slot_icon_placer_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef GRID_SLOT_ICON_PLACER_MACROS_SVH
`define GRID_SLOT_ICON_PLACER_MACROS_SVH
`ifndef SYNTH
// property that holds at every edge out of reset
`define GSIP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// same-cycle implication
`define GSIP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GSIP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define GSIP_ASSERT(lbl, prop, msg)
`define GSIP_ASSERT_IMP(lbl, ante, cons, msg)
`define GSIP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/gsip_pkg.sv
`timescale 1ns / 1ps
package gsip_pkg;
   localparam int ACT_W      = 2;
   localparam int COORD_W    = 16;
   localparam int OUT_W      = 15;
   localparam int SLOT_W     = 8;
   localparam int NUM_SLOTS  = 256;
   localparam int POL_W      = 3;
   localparam int ISZ_W      = 13;
   localparam int SCR_W      = 15;
   localparam int BW_W       = 8;
   localparam int WGT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int POS_W      = 26;
   localparam int FP_W       = 14;
   localparam int OV_W       = 14;
   localparam int AREA_W     = 2 * OV_W;
   localparam int WCOST_W    = WGT_W + AREA_W;
   localparam int ROWC_W     = SLOT_W + WGT_W;
   localparam int DIV_Q_W    = 15;
   localparam int DIV_D_W    = 14;

   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ICON   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_WINDOW = 2'd2;
   localparam logic [ACT_W-1:0] ACT_PLACE  = 2'd3;

   localparam logic [POL_W-1:0] POL_LEFT   = 3'd0;
   localparam logic [POL_W-1:0] POL_RIGHT  = 3'd1;
   localparam logic [POL_W-1:0] POL_BOTTOM = 3'd2;
   localparam logic [POL_W-1:0] POL_TOP    = 3'd3;
   localparam logic [POL_W-1:0] POL_SMART  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_POLICY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ICON_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ICON_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCR_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCR_HEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BORDER      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WEIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PIX_WEIGHT  = 3'd7;

   localparam logic signed [POS_W-1:0] OUT_MAX = POS_W'(32767);

   typedef logic signed [POS_W-1:0] pos_type;

   function automatic pos_type ext_coord(input logic [COORD_W-1:0] v);
      return {{(POS_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   function automatic logic [OUT_W-1:0] clamp_out(input pos_type v, input pos_type m);
      logic [OUT_W-1:0] r;
      if (v < m) r = OUT_W'(m);
      else if (v > OUT_MAX) r = '1;
      else r = v[OUT_W-1:0];
      return r;
   endfunction
endpackage

>>> hdl/gsip_if.sv
`timescale 1ns / 1ps
interface gsip_req_if;
   logic valid;
   logic ready;
   logic [gsip_pkg::ACT_W-1:0] action;
   logic signed [gsip_pkg::COORD_W-1:0] pos_x;
   logic signed [gsip_pkg::COORD_W-1:0] pos_y;
   logic [gsip_pkg::COORD_W-1:0] rect_w;
   logic [gsip_pkg::COORD_W-1:0] rect_h;
   modport source (output valid, action, pos_x, pos_y, rect_w, rect_h, input ready);
   modport sink (input valid, action, pos_x, pos_y, rect_w, rect_h, output ready);
endinterface

interface gsip_rsp_if;
   logic valid;
   logic ready;
   logic [gsip_pkg::OUT_W-1:0] place_x;
   logic [gsip_pkg::OUT_W-1:0] place_y;
   logic [gsip_pkg::SLOT_W-1:0] slot_index;
   modport source (output valid, place_x, place_y, slot_index, input ready);
   modport sink (input valid, place_x, place_y, slot_index, output ready);
endinterface

interface gsip_csr_if;
   logic valid;
   logic ready;
   logic [gsip_pkg::CSR_IDX_W-1:0] index;
   logic [gsip_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/grid_slot_icon_placer.sv
`timescale 1ns / 1ps
// grid slot icon placer
// req_ch: one transfer per request; action clear, add icon corner, add window
//   rectangle, or place. clear and add produce no response; a new request
//   is accepted in the next cycle.
// rsp_ch: one transfer per place request, carrying place_x, place_y and
//   slot_index. the response sits in an output register, so load requests keep
//   flowing while it waits for rsp_ch.ready.
// csr_ch: register writes, always ready; write only while no place is running.
// a place request runs the grid pitch divider, then visits slots in order;
//   each visited slot scans every stored icon corner, and a smart slot that
//   survives the icon check also scans every window; up to 256 slots are
//   visited.
// the icon scan reads one stored corner per cycle from the icon memory; the
//   smart cost reads one window per cycle through a four-stage overlap and
//   multiply pipeline. memory read ports set these figures.
// during a place request req_ch.ready is low; a stalled response holds the
//   next place result in its final state until the output register frees up.
// reset: synchronous, clears counts, control state and registers to defaults;
//   the stores themselves are not cleared, the counts gate every read.
`include "grid_slot_icon_placer_macros.svh"
module grid_slot_icon_placer #(
   parameter int MAX_ICONS   = 256,
   parameter int MAX_WINDOWS = 64,
   parameter int GRID_MARGIN = 8
) (
   input logic         clock,
   input logic         reset,
   gsip_req_if.sink    req_ch,
   gsip_rsp_if.source  rsp_ch,
   gsip_csr_if.sink    csr_ch
);
   localparam int IA_W   = (MAX_ICONS > 1) ? $clog2(MAX_ICONS) : 1;
   localparam int ICNT_W = $clog2(MAX_ICONS + 1);
   localparam int WA_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int WCNT_W = $clog2(MAX_WINDOWS + 1);
   localparam int COST_W = gsip_pkg::WCOST_W + $clog2(MAX_WINDOWS + 1) + 1;
   localparam int POS_W  = gsip_pkg::POS_W;
   localparam int CW     = gsip_pkg::COORD_W;
   localparam int FP_W   = gsip_pkg::FP_W;
   localparam int OV_W   = gsip_pkg::OV_W;
   localparam int SLOT_W = gsip_pkg::SLOT_W;
   localparam int QW     = gsip_pkg::DIV_Q_W;
   localparam int SCR_W  = gsip_pkg::SCR_W;

   localparam logic [FP_W-1:0]  MARGIN   = FP_W'(GRID_MARGIN);
   localparam gsip_pkg::pos_type MARGIN_S = POS_W'(GRID_MARGIN);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_SLOT  = 4'd2;
   localparam logic [3:0] S_TEST  = 4'd3;
   localparam logic [3:0] S_ICON  = 4'd4;
   localparam logic [3:0] S_EVAL  = 4'd5;
   localparam logic [3:0] S_WIN   = 4'd6;
   localparam logic [3:0] S_JUDGE = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   // configuration registers
   logic [gsip_pkg::POL_W-1:0] policy_ff;
   logic [gsip_pkg::ISZ_W-1:0] iw_ff, ih_ff;
   logic [SCR_W-1:0]           sw_ff, sh_ff;
   logic [gsip_pkg::BW_W-1:0]  bw_ff;
   logic [gsip_pkg::WGT_W-1:0] rw_ff, pw_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= gsip_pkg::POL_TOP;
         iw_ff     <= 13'd64;
         ih_ff     <= 13'd64;
         sw_ff     <= 15'd1920;
         sh_ff     <= 15'd1080;
         bw_ff     <= 8'd0;
         rw_ff     <= 16'd1000;
         pw_ff     <= 16'd1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            gsip_pkg::REG_POLICY:      policy_ff <= csr_ch.data[gsip_pkg::POL_W-1:0];
            gsip_pkg::REG_ICON_WIDTH:  iw_ff <= csr_ch.data[gsip_pkg::ISZ_W-1:0];
            gsip_pkg::REG_ICON_HEIGHT: ih_ff <= csr_ch.data[gsip_pkg::ISZ_W-1:0];
            gsip_pkg::REG_SCR_WIDTH:   sw_ff <= csr_ch.data[SCR_W-1:0];
            gsip_pkg::REG_SCR_HEIGHT:  sh_ff <= csr_ch.data[SCR_W-1:0];
            gsip_pkg::REG_BORDER:      bw_ff <= csr_ch.data[gsip_pkg::BW_W-1:0];
            gsip_pkg::REG_ROW_WEIGHT:  rw_ff <= csr_ch.data;
            gsip_pkg::REG_PIX_WEIGHT:  pw_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // control and datapath registers
   logic [3:0]        state_ff, state_in;
   logic [ICNT_W-1:0] icon_cnt_ff, icon_cnt_in;
   logic [WCNT_W-1:0] win_cnt_ff, win_cnt_in;
   logic              smart_ff, smart_in;
   logic              pri_on_x_ff, pri_on_x_in;
   logic              sec_neg_ff, sec_neg_in;
   logic              div_need_ff, div_need_in;
   gsip_pkg::pos_type base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic [FP_W-1:0]   pitch_pri_ff, pitch_pri_in, pitch_sec_ff, pitch_sec_in;
   logic [FP_W-1:0]   fw_ff, fw_in, fh_ff, fh_in;
   logic [QW-1:0]     maxp_ff, maxp_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, pri_ff, pri_in, sec_ff, sec_in;
   gsip_pkg::pos_type pri_off_ff, pri_off_in, sec_off_ff, sec_off_in;
   gsip_pkg::pos_type x_ff, x_in, y_ff, y_in;
   gsip_pkg::pos_type chosen_x_ff, chosen_x_in, chosen_y_ff, chosen_y_in;
   logic [SLOT_W-1:0] chosen_ff, chosen_in;
   logic [COST_W-1:0] cost_ff, cost_in, best_ff, best_in;
   logic              best_v_ff, best_v_in;
   logic              touch_ff, touch_in;
   logic [ICNT_W-1:0] ik_ff, ik_in;
   logic              irv_ff, irv_in;
   logic [WCNT_W-1:0] wk_ff, wk_in;
   logic              wrv_ff, wrv_in;
   logic              s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic [OV_W-1:0]   ovx_ff, ovx_in, ovy_ff, ovy_in;
   logic [gsip_pkg::AREA_W-1:0]  area_ff, area_in;
   logic [gsip_pkg::WCOST_W-1:0] wcost_ff, wcost_in;
   logic              rsp_v_ff, rsp_v_in;
   logic [gsip_pkg::OUT_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic req_acc, out_free, icon_rd, win_rd, icon_wr, win_wr, div_start, div_done;
   logic [QW-1:0]     div_q;
   logic [2*CW-1:0]   icon_q;
   logic [4*CW-1:0]   win_q;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_v_ff || rsp_ch.ready;

   assign icon_wr = req_acc && (req_ch.action == gsip_pkg::ACT_ICON) &&
                    (icon_cnt_ff < ICNT_W'(MAX_ICONS));
   assign win_wr  = req_acc && (req_ch.action == gsip_pkg::ACT_WINDOW) &&
                    (win_cnt_ff < WCNT_W'(MAX_WINDOWS));
   assign icon_rd = (state_ff == S_ICON) && (ik_ff < icon_cnt_ff);
   assign win_rd  = (state_ff == S_WIN) && (wk_ff < win_cnt_ff);

   gsip_ram #(.WIDTH(2 * CW), .DEPTH(MAX_ICONS)) u_icon_ram (
      .clock   (clock),
      .wr_en   (icon_wr),
      .wr_addr (icon_cnt_ff[IA_W-1:0]),
      .wr_data ({req_ch.pos_x, req_ch.pos_y}),
      .rd_en   (icon_rd),
      .rd_addr (ik_ff[IA_W-1:0]),
      .rd_data (icon_q)
   );

   gsip_ram #(.WIDTH(4 * CW), .DEPTH(MAX_WINDOWS)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr),
      .wr_addr (win_cnt_ff[WA_W-1:0]),
      .wr_data ({req_ch.pos_x, req_ch.pos_y, req_ch.rect_w, req_ch.rect_h}),
      .rd_en   (win_rd),
      .rd_addr (wk_ff[WA_W-1:0]),
      .rd_data (win_q)
   );

   // setup values for a place request, from the layout policy
   logic [gsip_pkg::POL_W-1:0] pol_eff;
   logic                       su_pri_on_x;
   logic [SCR_W-1:0]           su_scr;
   logic [gsip_pkg::ISZ_W-1:0] su_isz;
   logic [FP_W-1:0]            su_step, su_sx, su_sy, su_bt;
   logic [QW-1:0]              su_dividend;
   logic [gsip_pkg::DIV_D_W-1:0] su_divisor;
   gsip_pkg::pos_type          su_right_x, su_bottom_y;

   always_comb begin
      if (policy_ff == gsip_pkg::POL_SMART) pol_eff = gsip_pkg::POL_BOTTOM;
      else if (policy_ff > gsip_pkg::POL_TOP) pol_eff = gsip_pkg::POL_TOP;
      else pol_eff = policy_ff;
   end

   assign su_pri_on_x = (pol_eff == gsip_pkg::POL_BOTTOM) || (pol_eff == gsip_pkg::POL_TOP);
   assign su_scr      = su_pri_on_x ? sw_ff : sh_ff;
   assign su_isz      = su_pri_on_x ? iw_ff : ih_ff;
   assign su_step     = FP_W'(su_isz) + MARGIN;
   assign su_dividend = su_scr - QW'(MARGIN);
   assign su_divisor  = (su_step == '0) ? gsip_pkg::DIV_D_W'(1) : su_step;
   assign su_sx       = FP_W'(iw_ff) + MARGIN;
   assign su_sy       = FP_W'(ih_ff) + MARGIN;
   assign su_bt       = FP_W'({bw_ff, 1'b0});
   assign su_right_x  = POS_W'(sw_ff) - POS_W'(iw_ff) - MARGIN_S - POS_W'(su_bt);
   assign su_bottom_y = POS_W'(sh_ff) - POS_W'(ih_ff) - MARGIN_S - POS_W'(su_bt);

   assign div_start = req_acc && (req_ch.action == gsip_pkg::ACT_PLACE);

   gsip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (su_dividend),
      .divisor  (su_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // slot pixel position from the running grid offsets
   gsip_pkg::pos_type sec_term, x_calc, y_calc;
   assign sec_term = sec_neg_ff ? -sec_off_ff : sec_off_ff;
   assign x_calc   = base_x_ff + (pri_on_x_ff ? pri_off_ff : sec_term);
   assign y_calc   = base_y_ff + (pri_on_x_ff ? sec_term : pri_off_ff);

   // icon footprint overlap test against the corner read from memory
   gsip_pkg::pos_type fw_s, fh_s, dx, dy;
   logic icon_hit;
   assign fw_s = POS_W'(fw_ff);
   assign fh_s = POS_W'(fh_ff);
   assign dx   = x_ff - gsip_pkg::ext_coord(icon_q[2*CW-1:CW]);
   assign dy   = y_ff - gsip_pkg::ext_coord(icon_q[CW-1:0]);
   assign icon_hit = (fw_ff != '0) && (fh_ff != '0) && (dx < fw_s) && (-dx < fw_s) &&
                     (dy < fh_s) && (-dy < fh_s);

   // window overlap spans
   gsip_pkg::pos_type wl_s, wt_s, x_end, y_end, wx_end, wy_end;
   gsip_pkg::pos_type lo_x, hi_x, lo_y, hi_y;
   assign wl_s   = gsip_pkg::ext_coord(win_q[4*CW-1:3*CW]);
   assign wt_s   = gsip_pkg::ext_coord(win_q[3*CW-1:2*CW]);
   assign x_end  = x_ff + fw_s;
   assign y_end  = y_ff + fh_s;
   assign wx_end = wl_s + POS_W'(win_q[2*CW-1:CW]);
   assign wy_end = wt_s + POS_W'(win_q[CW-1:0]);
   assign lo_x   = (x_ff > wl_s) ? x_ff : wl_s;
   assign hi_x   = (x_end < wx_end) ? x_end : wx_end;
   assign lo_y   = (y_ff > wt_s) ? y_ff : wt_s;
   assign hi_y   = (y_end < wy_end) ? y_end : wy_end;

   logic [gsip_pkg::ROWC_W-1:0] row_cost;
   assign row_cost = sec_ff * rw_ff;

   always_comb begin
      state_in     = state_ff;
      icon_cnt_in  = icon_cnt_ff;
      win_cnt_in   = win_cnt_ff;
      smart_in     = smart_ff;
      pri_on_x_in  = pri_on_x_ff;
      sec_neg_in   = sec_neg_ff;
      div_need_in  = div_need_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      pitch_pri_in = pitch_pri_ff;
      pitch_sec_in = pitch_sec_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      maxp_in      = maxp_ff;
      slot_in      = slot_ff;
      pri_in       = pri_ff;
      sec_in       = sec_ff;
      pri_off_in   = pri_off_ff;
      sec_off_in   = sec_off_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      chosen_in    = chosen_ff;
      chosen_x_in  = chosen_x_ff;
      chosen_y_in  = chosen_y_ff;
      cost_in      = cost_ff;
      best_in      = best_ff;
      best_v_in    = best_v_ff;
      touch_in     = touch_ff;
      ik_in        = ik_ff;
      irv_in       = icon_rd;
      wk_in        = wk_ff;
      wrv_in       = win_rd;
      s1_v_in      = wrv_ff;
      s2_v_in      = s1_v_ff;
      s3_v_in      = s2_v_ff;
      ovx_in       = (hi_x > lo_x) ? OV_W'(hi_x - lo_x) : '0;
      ovy_in       = (hi_y > lo_y) ? OV_W'(hi_y - lo_y) : '0;
      area_in      = ovx_ff * ovy_ff;
      wcost_in     = pw_ff * area_ff;
      rsp_v_in     = rsp_v_ff && !rsp_ch.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_slot_in  = rsp_slot_ff;

      if (icon_wr) icon_cnt_in = icon_cnt_ff + 1'b1;
      if (win_wr)  win_cnt_in  = win_cnt_ff + 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_ch.action)
                  gsip_pkg::ACT_CLEAR: begin
                     icon_cnt_in = '0;
                     win_cnt_in  = '0;
                  end
                  gsip_pkg::ACT_PLACE: begin
                     smart_in     = (policy_ff == gsip_pkg::POL_SMART);
                     pri_on_x_in  = su_pri_on_x;
                     sec_neg_in   = (pol_eff == gsip_pkg::POL_RIGHT) ||
                                    (pol_eff == gsip_pkg::POL_BOTTOM);
                     div_need_in  = su_scr > SCR_W'(su_step);
                     base_x_in    = (pol_eff == gsip_pkg::POL_RIGHT) ? su_right_x : MARGIN_S;
                     base_y_in    = (pol_eff == gsip_pkg::POL_BOTTOM) ? su_bottom_y : MARGIN_S;
                     pitch_pri_in = su_pri_on_x ? su_sx : su_sy;
                     pitch_sec_in = su_pri_on_x ? su_sy : su_sx;
                     fw_in        = FP_W'(iw_ff) + su_bt;
                     fh_in        = FP_W'(ih_ff) + su_bt;
                     slot_in      = '0;
                     pri_in       = '0;
                     sec_in       = '0;
                     pri_off_in   = '0;
                     sec_off_in   = '0;
                     best_v_in    = 1'b0;
                     chosen_in    = '0;
                     state_in     = S_DIV;
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               maxp_in  = (div_need_ff && (div_q != '0)) ? div_q : QW'(1);
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            x_in    = x_calc;
            y_in    = y_calc;
            cost_in = COST_W'(row_cost);
            if (slot_ff == '0) begin
               chosen_x_in = x_calc;
               chosen_y_in = y_calc;
            end
            state_in = S_TEST;
         end
         S_TEST: begin
            touch_in = 1'b0;
            ik_in    = '0;
            if (smart_ff && (y_ff < MARGIN_S)) state_in = S_NEXT;
            else if (icon_cnt_ff == '0) state_in = S_EVAL;
            else state_in = S_ICON;
         end
         S_ICON: begin
            if (icon_rd) ik_in = ik_ff + 1'b1;
            if (irv_ff && icon_hit) touch_in = 1'b1;
            if ((ik_ff == icon_cnt_ff) && !irv_ff) state_in = S_EVAL;
         end
         S_EVAL: begin
            wk_in = '0;
            if (touch_ff) begin
               state_in = S_NEXT;
            end else if (!smart_ff) begin
               chosen_in   = slot_ff;
               chosen_x_in = x_ff;
               chosen_y_in = y_ff;
               state_in    = S_DONE;
            end else if (win_cnt_ff == '0) begin
               state_in = S_JUDGE;
            end else begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            if (win_rd) wk_in = wk_ff + 1'b1;
            if (s3_v_ff) cost_in = cost_ff + COST_W'(wcost_ff);
            if ((wk_ff == win_cnt_ff) && !wrv_ff && !s1_v_ff && !s2_v_ff && !s3_v_ff) begin
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            state_in = S_NEXT;
            if (!best_v_ff || (cost_ff < best_ff)) begin
               best_in     = cost_ff;
               best_v_in   = 1'b1;
               chosen_in   = slot_ff;
               chosen_x_in = x_ff;
               chosen_y_in = y_ff;
               if (cost_ff == '0) state_in = S_DONE;
            end
         end
         S_NEXT: begin
            if (slot_ff == SLOT_W'(gsip_pkg::NUM_SLOTS - 1)) begin
               state_in = S_DONE;
            end else begin
               slot_in = slot_ff + 1'b1;
               if ((QW'(pri_ff) + QW'(1)) == maxp_ff) begin
                  pri_in     = '0;
                  pri_off_in = '0;
                  sec_in     = sec_ff + 1'b1;
                  sec_off_in = sec_off_ff + POS_W'(pitch_sec_ff);
               end else begin
                  pri_in     = pri_ff + 1'b1;
                  pri_off_in = pri_off_ff + POS_W'(pitch_pri_ff);
               end
               state_in = S_SLOT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_x_in    = gsip_pkg::clamp_out(chosen_x_ff, MARGIN_S);
               rsp_y_in    = gsip_pkg::clamp_out(chosen_y_ff, MARGIN_S);
               rsp_slot_in = chosen_ff;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         icon_cnt_ff <= '0;
         win_cnt_ff  <= '0;
         irv_ff      <= 1'b0;
         wrv_ff      <= 1'b0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         rsp_v_ff    <= 1'b0;
         best_v_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         icon_cnt_ff <= icon_cnt_in;
         win_cnt_ff  <= win_cnt_in;
         irv_ff      <= irv_in;
         wrv_ff      <= wrv_in;
         s1_v_ff     <= s1_v_in;
         s2_v_ff     <= s2_v_in;
         s3_v_ff     <= s3_v_in;
         rsp_v_ff    <= rsp_v_in;
         best_v_ff   <= best_v_in;
      end
      smart_ff     <= smart_in;
      pri_on_x_ff  <= pri_on_x_in;
      sec_neg_ff   <= sec_neg_in;
      div_need_ff  <= div_need_in;
      base_x_ff    <= base_x_in;
      base_y_ff    <= base_y_in;
      pitch_pri_ff <= pitch_pri_in;
      pitch_sec_ff <= pitch_sec_in;
      fw_ff        <= fw_in;
      fh_ff        <= fh_in;
      maxp_ff      <= maxp_in;
      slot_ff      <= slot_in;
      pri_ff       <= pri_in;
      sec_ff       <= sec_in;
      pri_off_ff   <= pri_off_in;
      sec_off_ff   <= sec_off_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      chosen_ff    <= chosen_in;
      chosen_x_ff  <= chosen_x_in;
      chosen_y_ff  <= chosen_y_in;
      cost_ff      <= cost_in;
      best_ff      <= best_in;
      touch_ff     <= touch_in;
      ik_ff        <= ik_in;
      wk_ff        <= wk_in;
      ovx_ff       <= ovx_in;
      ovy_ff       <= ovy_in;
      area_ff      <= area_in;
      wcost_ff     <= wcost_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.place_x    = rsp_x_ff;
   assign rsp_ch.place_y    = rsp_y_ff;
   assign rsp_ch.slot_index = rsp_slot_ff;

   `GSIP_ASSERT(a_icon_cnt_max, icon_cnt_ff <= ICNT_W'(MAX_ICONS), "icon count overflow")
   `GSIP_ASSERT(a_win_cnt_max, win_cnt_ff <= WCNT_W'(MAX_WINDOWS), "window count overflow")
   `GSIP_ASSERT_IMP(a_icon_scan, state_ff == S_ICON, ik_ff <= icon_cnt_ff, "icon scan overrun")
   `GSIP_ASSERT_IMP(a_pri_range, state_ff == S_SLOT, QW'(pri_ff) < maxp_ff, "grid column out of range")
   `GSIP_ASSERT_IMP(a_win_drain, state_ff != S_WIN, !(wrv_ff || s1_v_ff || s2_v_ff || s3_v_ff), "window pipe busy outside scan")
   `GSIP_ASSERT_NXT(a_rsp_load, (state_ff == S_DONE) && out_free, rsp_v_ff, "response not loaded")
endmodule

>>> hdl/gsip_ram.sv
`timescale 1ns / 1ps
module gsip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/gsip_div.sv
`timescale 1ns / 1ps
module gsip_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gsip_pkg::DIV_Q_W-1:0]  dividend,
   input  logic [gsip_pkg::DIV_D_W-1:0]  divisor,
   output logic                          done,
   output logic [gsip_pkg::DIV_Q_W-1:0]  quotient
);
   localparam int QW = gsip_pkg::DIV_Q_W;
   localparam int DW = gsip_pkg::DIV_D_W;
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[QW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import gsip_pkg::*;

   // one request as driven on req_ch, coordinates kept as raw 16-bit patterns
   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] rect_w;
      logic [COORD_W-1:0] rect_h;
   } request_t;

   // one placement as returned on rsp_ch
   typedef struct packed {
      logic [OUT_W-1:0]  px;
      logic [OUT_W-1:0]  py;
      logic [SLOT_W-1:0] slot;
   } spot_t;

   // directed row: request plus an optional hand-written placement
   typedef struct packed {
      request_t req;
      logic     typed;
      spot_t    want;
   } plan_row_t;

   localparam int MARGIN     = 8;
   localparam int ICON_DEPTH = 256;
   localparam int WIN_DEPTH  = 64;
   localparam int SLOTS      = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   gsip_req_if req_ch ();
   gsip_rsp_if rsp_ch ();
   gsip_csr_if csr_ch ();

   grid_slot_icon_placer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the register file
   int unsigned sh_policy, sh_icon_w, sh_icon_h, sh_scr_w, sh_scr_h;
   int unsigned sh_border, sh_row_wgt, sh_pix_wgt;

   // shadow copy of the icon and window stores
   int          icon_left [ICON_DEPTH];
   int          icon_top  [ICON_DEPTH];
   int unsigned icon_total;
   int          win_left  [WIN_DEPTH];
   int          win_top   [WIN_DEPTH];
   int unsigned win_wide  [WIN_DEPTH];
   int unsigned win_tall  [WIN_DEPTH];
   int unsigned win_total;

   spot_t due_spots[$];   // placements still owed by the block
   int    errors = 0;
   bit    quiet = 1'b0;   // no idling on either side while set
   bit    hold_req = 1'b0; // ask the receiver for one long stall

   // idle cycles before an item, drawn per item
   function automatic int gap_cycles();
      if (quiet || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   // length of the overlap of [a0, a0+al) and [b0, b0+bl)
   function automatic longint span_hit(longint a0, longint al, longint b0, longint bl);
      longint lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic bit hits_icon(longint x, longint y, longint fw, longint fh);
      for (int k = 0; k < icon_total; k++)
         if (span_hit(x, fw, icon_left[k], fw) != 0 && span_hit(y, fh, icon_top[k], fh) != 0)
            return 1'b1;
      return 1'b0;
   endfunction

   // slots along one edge before wrapping into the next row or column
   function automatic int unsigned edge_slots(int unsigned screen, int unsigned icon);
      int unsigned step, n;
      step = icon + MARGIN;
      n = (screen > step) ? (screen - MARGIN) / ((step != 0) ? step : 1) : 1;
      return (n != 0) ? n : 1;
   endfunction

   function automatic void slot_xy(int unsigned pol, int unsigned slot, int unsigned maxp,
                                   output longint px, output longint py);
      longint bt, sx, sy, pri, sec;
      bt  = 2 * longint'(sh_border);
      sx  = longint'(sh_icon_w) + MARGIN;
      sy  = longint'(sh_icon_h) + MARGIN;
      pri = slot % maxp;
      sec = slot / maxp;
      case (pol)
         POL_LEFT: begin
            px = MARGIN + sec * sx;
            py = MARGIN + pri * sy;
         end
         POL_RIGHT: begin
            px = longint'(sh_scr_w) - longint'(sh_icon_w) - MARGIN - bt - sec * sx;
            py = MARGIN + pri * sy;
         end
         POL_BOTTOM: begin
            px = MARGIN + pri * sx;
            py = longint'(sh_scr_h) - MARGIN - longint'(sh_icon_h) - bt - sec * sy;
         end
         default: begin
            px = MARGIN + pri * sx;
            py = MARGIN + sec * sy;
         end
      endcase
   endfunction

   function automatic logic [OUT_W-1:0] saturate(longint v);
      if (v < MARGIN) v = MARGIN;
      if (v > 32767) v = 32767;
      return v[OUT_W-1:0];
   endfunction

   // the slot the block is expected to pick for a place request
   function automatic spot_t choose_spot();
      longint fw, fh, x, y;
      longint unsigned cost, best;
      int unsigned pol, maxp, chosen;
      fw = longint'(sh_icon_w) + 2 * longint'(sh_border);
      fh = longint'(sh_icon_h) + 2 * longint'(sh_border);
      chosen = 0;
      if (sh_policy == POL_SMART) begin
         // smart search over the bottom layout, cheapest slot wins
         pol  = POL_BOTTOM;
         maxp = edge_slots(sh_scr_w, sh_icon_w);
         best = '1;
         for (int i = 0; i < SLOTS; i++) begin
            slot_xy(pol, i, maxp, x, y);
            if (y < MARGIN) continue;
            if (hits_icon(x, y, fw, fh)) continue;
            cost = longint'(i / maxp) * longint'(sh_row_wgt);
            for (int k = 0; k < win_total; k++)
               cost += longint'(sh_pix_wgt) *
                       (span_hit(x, fw, win_left[k], win_wide[k]) *
                        span_hit(y, fh, win_top[k], win_tall[k]));
            if (cost < best) begin
               best = cost;
               chosen = i;
               if (cost == 0) break;
            end
         end
      end else begin
         // undefined codes fall back to top
         pol = (sh_policy <= POL_TOP) ? sh_policy : POL_TOP;
         maxp = (pol == POL_LEFT || pol == POL_RIGHT) ? edge_slots(sh_scr_h, sh_icon_h)
                                                      : edge_slots(sh_scr_w, sh_icon_w);
         for (int i = 0; i < SLOTS; i++) begin
            slot_xy(pol, i, maxp, x, y);
            if (!hits_icon(x, y, fw, fh)) begin
               chosen = i;
               break;
            end
         end
      end
      slot_xy(pol, chosen, maxp, x, y);
      return '{saturate(x), saturate(y), chosen[SLOT_W-1:0]};
   endfunction

   // update the shadow state for one accepted request
   function automatic void absorb(request_t r, bit typed, spot_t want);
      spot_t s;
      case (r.action)
         ACT_CLEAR: begin
            icon_total = 0;
            win_total = 0;
         end
         ACT_ICON: if (icon_total < ICON_DEPTH) begin
            icon_left[icon_total] = $signed(r.pos_x);
            icon_top[icon_total]  = $signed(r.pos_y);
            icon_total++;
         end
         ACT_WINDOW: if (win_total < WIN_DEPTH) begin
            win_left[win_total] = $signed(r.pos_x);
            win_top[win_total]  = $signed(r.pos_y);
            win_wide[win_total] = r.rect_w;
            win_tall[win_total] = r.rect_h;
            win_total++;
         end
         default: begin
            s = choose_spot();
            due_spots.push_back(typed ? want : s);
         end
      endcase
   endfunction

   // offer one request and wait for its transfer
   task automatic send(request_t r, bit typed = 1'b0, spot_t want = '0);
      int g;
      g = gap_cycles();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= r.action;
      req_ch.pos_x  <= r.pos_x;
      req_ch.pos_y  <= r.pos_y;
      req_ch.rect_w <= r.rect_w;
      req_ch.rect_h <= r.rect_h;
      do @(posedge clock); while (!req_ch.ready);
      absorb(r, typed, want);
   endtask

   // drain everything owed, then let trailing loads finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (due_spots.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         REG_POLICY:      sh_policy  = data & 16'h0007;
         REG_ICON_WIDTH:  sh_icon_w  = data & 16'h1FFF;
         REG_ICON_HEIGHT: sh_icon_h  = data & 16'h1FFF;
         REG_SCR_WIDTH:   sh_scr_w   = data & 16'h7FFF;
         REG_SCR_HEIGHT:  sh_scr_h   = data & 16'h7FFF;
         REG_BORDER:      sh_border  = data & 16'h00FF;
         REG_ROW_WEIGHT:  sh_row_wgt = data;
         default:         sh_pix_wgt = data;
      endcase
   endtask

   task automatic write_all(logic [CSR_DATA_W-1:0] pol, logic [CSR_DATA_W-1:0] iw,
                            logic [CSR_DATA_W-1:0] ih, logic [CSR_DATA_W-1:0] sw,
                            logic [CSR_DATA_W-1:0] sh, logic [CSR_DATA_W-1:0] bw,
                            logic [CSR_DATA_W-1:0] roww, logic [CSR_DATA_W-1:0] pixw);
      csr_write(REG_POLICY, pol);
      csr_write(REG_ICON_WIDTH, iw);
      csr_write(REG_ICON_HEIGHT, ih);
      csr_write(REG_SCR_WIDTH, sw);
      csr_write(REG_SCR_HEIGHT, sh);
      csr_write(REG_BORDER, bw);
      csr_write(REG_ROW_WEIGHT, roww);
      csr_write(REG_PIX_WEIGHT, pixw);
   endtask

   // icon corner near the grid of some edge, sometimes anywhere at all
   function automatic request_t rand_icon();
      longint col, row, x, y;
      col = $urandom_range(0, 6);
      row = $urandom_range(0, 4);
      if ($urandom_range(0, 4) == 0)
         return '{ACT_ICON, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      case ($urandom_range(0, 2))
         0: begin
            x = MARGIN + col * (sh_icon_w + MARGIN);
            y = MARGIN + row * (sh_icon_h + MARGIN);
         end
         1: begin
            x = longint'(sh_scr_w) - sh_icon_w - MARGIN - 2 * sh_border - col * (sh_icon_w + MARGIN);
            y = MARGIN + row * (sh_icon_h + MARGIN);
         end
         default: begin
            x = MARGIN + col * (sh_icon_w + MARGIN);
            y = longint'(sh_scr_h) - sh_icon_h - MARGIN - 2 * sh_border - row * (sh_icon_h + MARGIN);
         end
      endcase
      // small jitter so partial overlaps show up too
      if ($urandom_range(0, 2) == 0) begin
         x += longint'($urandom_range(0, 8)) - 4;
         y += longint'($urandom_range(0, 8)) - 4;
      end
      return '{ACT_ICON, 16'(x), 16'(y), 16'($urandom), 16'($urandom)};
   endfunction

   function automatic request_t rand_window();
      if ($urandom_range(0, 4) == 0)
         return '{ACT_WINDOW, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      return '{ACT_WINDOW, 16'(longint'($urandom_range(0, sh_scr_w + 100)) - 100),
               16'(longint'($urandom_range(0, sh_scr_h + 100)) - 100),
               16'($urandom_range(0, sh_scr_w)), 16'($urandom_range(0, sh_scr_h))};
   endfunction

   // response side: random stalls, one long hold on request, compare in order
   initial begin
      int    wait_n;
      spot_t want;
      rsp_ch.ready <= 1'b0;
      wait_n = gap_cycles();
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_spots.size() == 0) begin
               $display("%t unexpected placement: x %0d y %0d slot %0d", $time,
                        rsp_ch.place_x, rsp_ch.place_y, rsp_ch.slot_index);
               errors++;
            end else begin
               want = due_spots.pop_front();
               if (rsp_ch.place_x !== want.px) begin
                  $display("%t place_x mismatch: expected %0d, got %0d", $time,
                           want.px, rsp_ch.place_x);
                  errors++;
               end
               if (rsp_ch.place_y !== want.py) begin
                  $display("%t place_y mismatch: expected %0d, got %0d", $time,
                           want.py, rsp_ch.place_y);
                  errors++;
               end
               if (rsp_ch.slot_index !== want.slot) begin
                  $display("%t slot_index mismatch: expected %0d, got %0d", $time,
                           want.slot, rsp_ch.slot_index);
                  errors++;
               end
            end
            wait_n = hold_req ? 3000 : gap_cycles();
            hold_req = 1'b0;
            if (wait_n > 0) rsp_ch.ready <= 1'b0;
         end else if (!rsp_ch.ready) begin
            if (wait_n <= 0) rsp_ch.ready <= 1'b1;
            else wait_n--;
         end
      end
   end

   // stimulus
   initial begin
      plan_row_t plan[$];
      longint    x, y;
      int        made, n;
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_CLEAR;
      req_ch.pos_x  <= '0;
      req_ch.pos_y  <= '0;
      req_ch.rect_w <= '0;
      req_ch.rect_h <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.index  <= REG_POLICY;
      csr_ch.data   <= '0;

      // register defaults, stores empty
      sh_policy = POL_TOP;  sh_icon_w = 64;   sh_icon_h = 64;   sh_scr_w = 1920;
      sh_scr_h = 1080;      sh_border = 0;    sh_row_wgt = 1000; sh_pix_wgt = 1;
      icon_total = 0;
      win_total = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, default registers: top edge, 26 slots per row, pitch 72
      plan = '{
         '{'{ACT_PLACE, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{15'd8, 15'd8, 8'd0}},
         '{'{ACT_ICON, 16'd8, 16'd8, 16'd0, 16'd0}, 1'b0, '0},
         '{'{ACT_PLACE, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{15'd80, 15'd8, 8'd1}},
         '{'{ACT_ICON, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
         '{'{ACT_ICON, 16'h7FFF, 16'h8000, 16'd0, 16'd0}, 1'b0, '0},
         '{'{ACT_ICON, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
         '{'{ACT_WINDOW, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
         '{'{ACT_WINDOW, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
         '{'{ACT_WINDOW, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd0}, 1'b0, '0},
         '{'{ACT_PLACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
         '{'{ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
         '{'{ACT_PLACE, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{15'd8, 15'd8, 8'd0}}
      };
      foreach (plan[i]) send(plan[i].req, plan[i].typed, plan[i].want);

      // every policy code, the undefined ones included, with the stores empty
      for (int p = 0; p < 8; p++) begin
         settle();
         csr_write(REG_POLICY, 16'(p));
         send('{ACT_PLACE, 16'd0, 16'd0, 16'd0, 16'd0});
      end

      // full stores: every top-edge slot covered, so the fallback slot comes back
      settle();
      csr_write(REG_POLICY, POL_TOP);
      send('{ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0});
      for (int i = 0; i <= ICON_DEPTH; i++)
         send('{ACT_ICON, 16'(MARGIN + (i % 26) * 72), 16'(MARGIN + (i / 26) * 72), 16'd0, 16'd0});
      for (int i = 0; i <= WIN_DEPTH; i++) send(rand_window());
      send('{ACT_PLACE, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{15'd8, 15'd8, 8'd0});

      // random phases, each under its own register setting
      for (int ph = 0; ph < 10; ph++) begin
         settle();
         case (ph)
            0: write_all(POL_SMART, 64, 64, 1920, 1080, 0, 1000, 1);
            1: write_all(16'hFFFC, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF);
            2: write_all(POL_SMART, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
            default: begin
               if (ph % 4 == 0)
                  write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
               else
                  write_all(($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 7)) : POL_SMART,
                            16'($urandom_range(1, 128)), 16'($urandom_range(1, 128)),
                            16'($urandom_range(64, 4096)), 16'($urandom_range(64, 4096)),
                            16'($urandom_range(0, 8)), 16'($urandom), 16'($urandom_range(0, 300)));
            end
         endcase
         quiet = (ph % 4 == 3);
         if (ph == 5) hold_req = 1'b1;
         made = 0;
         while (made < 150) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any request at all
               send('{2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
               made++;
            end else begin
               // well-formed: optional clear, some icons, some windows, one or two places
               if ($urandom_range(0, 1) == 0) begin
                  send('{ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
                  made++;
               end
               n = $urandom_range(0, 6);
               repeat (n) send(rand_icon());
               made += n;
               n = $urandom_range(0, 4);
               repeat (n) send(rand_window());
               made += n;
               n = $urandom_range(1, 2);
               repeat (n) send('{ACT_PLACE, 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom)});
               made += n;
            end
         end
      end

      // drain and let the block run out
      req_ch.valid <= 1'b0;
      while (due_spots.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // watchdog for a hung handshake
   initial begin
      #40000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/gsip_pkg.sv
hdl/gsip_if.sv
hdl/gsip_ram.sv
hdl/gsip_div.sv
hdl/grid_slot_icon_placer.sv
tb/tb_top.sv
